@@ hw/rtl/matrix_multiply_accumulate_rows_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply-accumulate block
// Shared concurrent assertion forms, clocked on a given clock and disabled in
// reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_ROWS_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_ROWS_TOP_MACROS_SVH

// Same-cycle implication: con must hold whenever ant holds.
`define MMAR_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication: con must hold in the cycle after ant.
`define MMAR_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

@@ hw/rtl/mmar_pkg.sv @@
// ----------------------------------------------------------------------------
// mmar_pkg
// Types and fixed widths shared by the matrix multiply-accumulate block and
// its checker.
// ----------------------------------------------------------------------------
package mmar_pkg;

	// Fixed field widths
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 8;
	localparam int COORD_W = 4;
	localparam int PART_W  = 2;

	// Input item operations
	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_WRITE_C = 2'd2,
		OP_COMPUTE = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_C,
		ST_MAC,
		ST_DRAIN
	} state_t;

endpackage

@@ hw/rtl/matrix_multiply_accumulate_rows_top.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_rows_top
// Integer matrix multiply-accumulate over a band of rows: loads A, B and C
// element by element, then updates and streams out one band of C.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Content
// cfg       in         cfg_we                 part_select (band number)
// in        in         in_valid / in_ready    opcode, element_index, element_value
// out       out        out_valid / out_ready  result_row/column/value, last_of_band
//
// A write item leaves the block idle, so it is ready again in the next cycle.
// A compute item runs each band element through a C read, then one
// multiply-accumulate per cycle through the single 32x32 multiplier, then a
// pipeline drain before the element is written back and emitted.
// After reset a clearing pass zeroes every cell of the C memory, during which
// no item is accepted; configuration writes are taken as ever.
// A stalled output holds the sequencer before the next element is written
// back; the last result register lets the next item in while it waits.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_rows_top #(
	parameter int MATRIX_SIZE = 16,
	parameter int PART_COUNT  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mmar_pkg::PART_W-1:0]      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  mmar_pkg::op_t                    opcode,
	input  logic [mmar_pkg::INDEX_W-1:0]     element_index,
	input  logic [mmar_pkg::DATA_W-1:0]      element_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mmar_pkg::COORD_W-1:0]     result_row,
	output logic [mmar_pkg::COORD_W-1:0]     result_column,
	output logic [mmar_pkg::DATA_W-1:0]      result_value,
	output logic                             last_of_band
);
	import mmar_pkg::*;

	localparam int CELLS  = MATRIX_SIZE * MATRIX_SIZE;
	localparam int CELL_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(MATRIX_SIZE);
	localparam int BAND   = MATRIX_SIZE / PART_COUNT;
	localparam int BW     = ROW_W + 3;

	// Element memories
	logic [DATA_W-1:0] a_mem [CELLS];
	logic [DATA_W-1:0] b_mem [CELLS];
	logic [DATA_W-1:0] c_mem [CELLS];

	state_t            state_q, state_d;
	logic [PART_W-1:0] part_q;
	logic [CELL_W-1:0] clr_q;
	logic [BW-1:0]     row_q, end_row_q;
	logic [ROW_W-1:0]  col_q, k_q;
	logic [DATA_W-1:0] a_rd_s1, b_rd_s1, prod_s2, c_rd_q, acc_q;
	logic              vld_s1, vld_s2;
	logic              out_valid_q;

	// Band bounds
	logic [BW-1:0]     band_start, band_stop, band_lim, band_end;
	logic              band_ok;

	// Addresses and strobes
	logic [CELL_W-1:0] wr_idx, c_addr, a_addr, b_addr;
	logic              idx_ok, last_col, last_row, last_k;
	logic              wr_a, wr_b, c_we, c_re, mac_issue, start_band, elem_done;
	logic [CELL_W-1:0] c_waddr;
	logic [DATA_W-1:0] c_wdata;

	assign band_start = BW'(part_q) * BW'(BAND);
	assign band_stop  = band_start + BW'(BAND);
	assign band_lim   = (band_stop > BW'(MATRIX_SIZE)) ? BW'(MATRIX_SIZE) : band_stop;
	assign band_end   = band_lim - BW'(1);
	assign band_ok    = (BAND != 0) && (band_start < BW'(MATRIX_SIZE));

	assign idx_ok = 32'(element_index) < 32'(CELLS);
	assign wr_idx = CELL_W'(element_index);
	assign c_addr = CELL_W'(row_q[ROW_W-1:0]) * CELL_W'(MATRIX_SIZE) + CELL_W'(col_q);
	assign a_addr = CELL_W'(row_q[ROW_W-1:0]) * CELL_W'(MATRIX_SIZE) + CELL_W'(k_q);
	assign b_addr = CELL_W'(k_q) * CELL_W'(MATRIX_SIZE) + CELL_W'(col_q);

	assign last_col = col_q == ROW_W'(MATRIX_SIZE - 1);
	assign last_k   = k_q == ROW_W'(MATRIX_SIZE - 1);
	assign last_row = row_q == end_row_q;

	// Sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		wr_a       = 1'b0;
		wr_b       = 1'b0;
		c_we       = 1'b0;
		c_waddr    = c_addr;
		c_wdata    = acc_q;
		c_re       = 1'b0;
		mac_issue  = 1'b0;
		start_band = 1'b0;
		elem_done  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_wdata = '0;
				if (clr_q == CELL_W'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_COMPUTE) begin
						if (band_ok) begin
							start_band = 1'b1;
							state_d    = ST_LOAD_C;
						end
					end else if (idx_ok) begin
						wr_a    = opcode == OP_WRITE_A;
						wr_b    = opcode == OP_WRITE_B;
						c_we    = opcode == OP_WRITE_C;
						c_waddr = wr_idx;
						c_wdata = element_value;
					end
				end
			end
			ST_LOAD_C: begin
				c_re    = 1'b1;
				state_d = ST_MAC;
			end
			ST_MAC: begin
				mac_issue = 1'b1;
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// Write back and emit once the pipeline is empty and the output is free
				if (!vld_s1 && !vld_s2 && (!out_valid_q || out_ready)) begin
					elem_done = 1'b1;
					c_we      = 1'b1;
					state_d   = (last_col && last_row) ? ST_IDLE : ST_LOAD_C;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, counters, pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q      <= '0;
			clr_q       <= '0;
			row_q       <= '0;
			end_row_q   <= '0;
			col_q       <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				part_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CELL_W'(1);
			end
			if (start_band) begin
				row_q     <= band_start;
				end_row_q <= band_end;
				col_q     <= '0;
			end
			if (c_re) begin
				k_q <= '0;
			end else if (mac_issue) begin
				k_q <= k_q + ROW_W'(1);
			end
			// Advance to the next element of the band
			if (elem_done) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + BW'(1);
				end else begin
					col_q <= col_q + ROW_W'(1);
				end
			end
			vld_s1 <= mac_issue;
			vld_s2 <= vld_s1;
			if (elem_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_mem[wr_idx] <= element_value;
		end
		if (wr_b) begin
			b_mem[wr_idx] <= element_value;
		end
		if (c_we) begin
			c_mem[c_waddr] <= c_wdata;
		end
	end

	// Memory reads, registered
	always_ff @(posedge clk) begin
		if (mac_issue) begin
			a_rd_s1 <= a_mem[a_addr];
			b_rd_s1 <= b_mem[b_addr];
		end
		if (c_re) begin
			c_rd_q <= c_mem[c_addr];
		end
	end

	// Shared multiply-accumulate unit
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (mac_issue && (k_q == '0)) begin
			acc_q <= c_rd_q;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (elem_done) begin
			result_row    <= COORD_W'(row_q);
			result_column <= COORD_W'(col_q);
			result_value  <= acc_q;
			last_of_band  <= last_col && last_row;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/mmar_checker.sv @@
// ----------------------------------------------------------------------------
// mmar_checker
// Port-level checks for the matrix multiply-accumulate block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "matrix_multiply_accumulate_rows_top_macros.svh"

module mmar_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input mmar_pkg::op_t                    opcode,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [mmar_pkg::COORD_W-1:0]     result_row,
	input logic [mmar_pkg::COORD_W-1:0]     result_column,
	input logic [mmar_pkg::DATA_W-1:0]      result_value,
	input logic                             last_of_band
);
	import mmar_pkg::*;

	// A stalled result stays offered
	`MMAR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A stalled result keeps its payload
	`MMAR_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(result_value) && $stable(result_row) && $stable(result_column) && $stable(last_of_band), "result changed while stalled")

	// Load items leave the block ready again in the next cycle
	`MMAR_ASSERT_NXT(a_write_one_cycle, clk, arst_n, in_valid && in_ready && (opcode != OP_COMPUTE), in_ready, "not ready after a write item")

	// Mid-band results mean the band is still running
	`MMAR_ASSERT_IMP(a_busy_mid_band, clk, arst_n, out_valid && !last_of_band, !in_ready, "ready while a band is in progress")

endmodule

bind matrix_multiply_accumulate_rows_top mmar_checker u_mmar_checker (.*);
